FILE: design/mwsm_pkg.sv
// Shared types, widths and constants of the mecanum wheel speed mixer.
package mwsm_pkg;

  // Field widths of the command, the registers and the results.
  localparam int SPEED_BITS    = 16;
  localparam int RPM_BITS      = 15;
  localparam int CFG_LEN_BITS  = 12;
  localparam int GAIN_BITS     = 24;
  localparam int LIMIT_BITS    = 15;
  localparam int LIM_RPM_BITS  = 14;

  localparam int NUM_WHEELS    = 4;
  localparam int WHEEL_FR      = 0;
  localparam int WHEEL_FL      = 1;
  localparam int WHEEL_BL      = 2;
  localparam int WHEEL_BR      = 3;

  // Internal datapath widths, many of them derived from the field widths above.
  localparam int Q_BITS        = 16;
  localparam int INV_DEG_BITS  = 11;
  localparam int ARM_BITS      = CFG_LEN_BITS + 3;
  localparam int LIN_BITS      = SPEED_BITS + 2;
  localparam int WARM_BITS     = SPEED_BITS + ARM_BITS;
  localparam int WK_BITS       = WARM_BITS + INV_DEG_BITS;
  localparam int SUM_BITS      = WK_BITS + 1;
  localparam int MAG_BITS      = SUM_BITS - 1;
  localparam int HALF_BITS     = MAG_BITS / 2;
  localparam int HI_BITS       = MAG_BITS - HALF_BITS;
  localparam int PROD_LO_BITS  = HALF_BITS + GAIN_BITS;
  localparam int PROD_HI_BITS  = HI_BITS + GAIN_BITS;
  localparam int FULL_BITS     = MAG_BITS + GAIN_BITS;
  localparam int RPM_FRAC_BITS = 40;
  localparam int RPM_MAG_BITS  = FULL_BITS - RPM_FRAC_BITS;
  localparam int NUM_BITS      = RPM_MAG_BITS + LIM_RPM_BITS;
  localparam int QUO_BITS      = LIM_RPM_BITS;
  localparam int DIV_STEPS     = QUO_BITS;
  localparam int RPM_MAX       = 2 ** (RPM_BITS - 1) - 1;

  // Round(65536 / 57.3): degrees to radians in Q16.
  localparam logic [INV_DEG_BITS-1:0] INV_DEG_Q16 = 11'd1144;

  // Per-wheel mixing signs, one bit per wheel, set where the term is subtracted.
  localparam logic [NUM_WHEELS-1:0] SX_NEG = 4'b1100;
  localparam logic [NUM_WHEELS-1:0] SY_NEG = 4'b1001;
  localparam logic [NUM_WHEELS-1:0] AX_NEG = 4'b0011;
  localparam logic [NUM_WHEELS-1:0] AY_NEG = 4'b0110;

  // Queue depths, powers of two so the pointers wrap by themselves.
  localparam int CMD_DEPTH     = 4;
  localparam int CMD_PTR_BITS  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_BITS  = $clog2(CMD_DEPTH + 1);
  localparam int RES_DEPTH     = 2;
  localparam int RES_PTR_BITS  = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS  = $clog2(RES_DEPTH + 1);

  // Register port.
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
  localparam int PADDR_BITS    = REG_IDX_BITS + 2;
  localparam int PDATA_BITS    = 32;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_RADIUS    = 3'd0,
    REG_OFFSET_X  = 3'd1,
    REG_OFFSET_Y  = 3'd2,
    REG_GAIN      = 3'd3,
    REG_LIMIT_VX  = 3'd4,
    REG_LIMIT_VY  = 3'd5,
    REG_LIMIT_WZ  = 3'd6,
    REG_LIMIT_RPM = 3'd7
  } reg_idx_e;

  localparam logic [CFG_LEN_BITS-1:0] RADIUS_RST    = 12'd523;
  localparam logic [GAIN_BITS-1:0]    GAIN_RST      = 24'd110960;
  localparam logic [LIMIT_BITS-1:0]   LIMIT_V_RST   = 15'd3000;
  localparam logic [LIMIT_BITS-1:0]   LIMIT_WZ_RST  = 15'd300;
  localparam logic [LIM_RPM_BITS-1:0] LIMIT_RPM_RST = 14'd8500;

  typedef struct packed {
    logic        [CFG_LEN_BITS-1:0] radius;
    logic signed [CFG_LEN_BITS-1:0] off_x;
    logic signed [CFG_LEN_BITS-1:0] off_y;
    logic        [GAIN_BITS-1:0]    gain;
    logic        [LIMIT_BITS-1:0]   lim_vx;
    logic        [LIMIT_BITS-1:0]   lim_vy;
    logic        [LIMIT_BITS-1:0]   lim_wz;
    logic        [LIM_RPM_BITS-1:0] lim_rpm;
  } cfg_t;

  // A clamped chassis command.
  typedef struct packed {
    logic signed [SPEED_BITS-1:0] vx;
    logic signed [SPEED_BITS-1:0] vy;
    logic signed [SPEED_BITS-1:0] wz;
  } cmd_t;

  // One wheel as it travels through the scaling divider.
  typedef struct packed {
    logic                    neg;
    logic [RPM_MAG_BITS-1:0] rpm_mag;
    logic [NUM_BITS-1:0]     rem;
    logic [QUO_BITS-1:0]     quo;
  } wheel_t;

  typedef struct packed {
    logic                          scaled;
    logic [RPM_MAG_BITS-1:0]       d;
    wheel_t [NUM_WHEELS-1:0]       w;
  } div_t;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][RPM_BITS-1:0] rpm;
    logic                                was_scaled;
  } res_t;

endpackage

FILE: design/mwsm_regs.sv
// Configuration register file behind the APB-style port.
module mwsm_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [mwsm_pkg::PADDR_BITS-1:0]     paddr_i,
  input  logic [mwsm_pkg::PDATA_BITS-1:0]     pwdata_i,
  output logic [mwsm_pkg::PDATA_BITS-1:0]     prdata_o,
  output mwsm_pkg::cfg_t                      cfg_o
);

  localparam int PB  = mwsm_pkg::PDATA_BITS;
  localparam int LB  = mwsm_pkg::CFG_LEN_BITS;
  localparam int GB  = mwsm_pkg::GAIN_BITS;
  localparam int VB  = mwsm_pkg::LIMIT_BITS;
  localparam int RB  = mwsm_pkg::LIM_RPM_BITS;
  localparam int AB  = mwsm_pkg::PADDR_BITS;

  mwsm_pkg::cfg_t     cfg_q, cfg_d;
  mwsm_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx   = mwsm_pkg::reg_idx_e'(paddr_i[AB-1:2]);
  assign wr_en = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        mwsm_pkg::REG_RADIUS:    cfg_d.radius  = pwdata_i[LB-1:0];
        mwsm_pkg::REG_OFFSET_X:  cfg_d.off_x   = signed'(pwdata_i[LB-1:0]);
        mwsm_pkg::REG_OFFSET_Y:  cfg_d.off_y   = signed'(pwdata_i[LB-1:0]);
        mwsm_pkg::REG_GAIN:      cfg_d.gain    = pwdata_i[GB-1:0];
        mwsm_pkg::REG_LIMIT_VX:  cfg_d.lim_vx  = pwdata_i[VB-1:0];
        mwsm_pkg::REG_LIMIT_VY:  cfg_d.lim_vy  = pwdata_i[VB-1:0];
        mwsm_pkg::REG_LIMIT_WZ:  cfg_d.lim_wz  = pwdata_i[VB-1:0];
        mwsm_pkg::REG_LIMIT_RPM: cfg_d.lim_rpm = pwdata_i[RB-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius  <= mwsm_pkg::RADIUS_RST;
      cfg_q.off_x   <= '0;
      cfg_q.off_y   <= '0;
      cfg_q.gain    <= mwsm_pkg::GAIN_RST;
      cfg_q.lim_vx  <= mwsm_pkg::LIMIT_V_RST;
      cfg_q.lim_vy  <= mwsm_pkg::LIMIT_V_RST;
      cfg_q.lim_wz  <= mwsm_pkg::LIMIT_WZ_RST;
      cfg_q.lim_rpm <= mwsm_pkg::LIMIT_RPM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Offsets read back as their raw twelve bits.
  always_comb begin
    case (idx)
      mwsm_pkg::REG_RADIUS:    prdata_o = PB'(cfg_q.radius);
      mwsm_pkg::REG_OFFSET_X:  prdata_o = PB'($unsigned(cfg_q.off_x));
      mwsm_pkg::REG_OFFSET_Y:  prdata_o = PB'($unsigned(cfg_q.off_y));
      mwsm_pkg::REG_GAIN:      prdata_o = PB'(cfg_q.gain);
      mwsm_pkg::REG_LIMIT_VX:  prdata_o = PB'(cfg_q.lim_vx);
      mwsm_pkg::REG_LIMIT_VY:  prdata_o = PB'(cfg_q.lim_vy);
      mwsm_pkg::REG_LIMIT_WZ:  prdata_o = PB'(cfg_q.lim_wz);
      mwsm_pkg::REG_LIMIT_RPM: prdata_o = PB'(cfg_q.lim_rpm);
      default:                 prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/mwsm_front.sv
// Command intake: clamps each velocity component and queues the command.
module mwsm_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mwsm_pkg::cfg_t                        cfg_i,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic signed [mwsm_pkg::SPEED_BITS-1:0] speed_x_i,
  input  logic signed [mwsm_pkg::SPEED_BITS-1:0] speed_y_i,
  input  logic signed [mwsm_pkg::SPEED_BITS-1:0] yaw_rate_i,
  output logic                                  cmd_valid_o,
  output mwsm_pkg::cmd_t                        cmd_o,
  input  logic                                  cmd_pop_i
);

  localparam int SB = mwsm_pkg::SPEED_BITS;
  localparam int VB = mwsm_pkg::LIMIT_BITS;
  localparam int CB = SB + VB;
  localparam int PB = mwsm_pkg::CMD_PTR_BITS;
  localparam int NB = mwsm_pkg::CMD_CNT_BITS;

  // Symmetric clamp of a signed value to +-lim.
  function automatic logic signed [SB-1:0] clamp_sym(input logic signed [SB-1:0] v,
                                                     input logic [VB-1:0] lim);
    logic signed [CB-1:0] v_x;
    logic signed [CB-1:0] l_x;
    logic signed [CB-1:0] r;
    v_x = CB'(v);
    l_x = signed'(CB'(lim));
    if (v_x > l_x) begin
      r = l_x;
    end else if (v_x < -l_x) begin
      r = -l_x;
    end else begin
      r = v_x;
    end
    return SB'(r);
  endfunction

  mwsm_pkg::cmd_t mem_q [mwsm_pkg::CMD_DEPTH];
  mwsm_pkg::cmd_t cmd_in;
  logic [PB-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NB-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  always_comb begin
    cmd_in.vx = clamp_sym(speed_x_i, cfg_i.lim_vx);
    cmd_in.vy = clamp_sym(speed_y_i, cfg_i.lim_vy);
    cmd_in.wz = clamp_sym(yaw_rate_i, cfg_i.lim_wz);
  end

  assign full_o      = (cnt_q == NB'(mwsm_pkg::CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign do_push     = push_i & ~full_o;
  assign do_pop      = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NB'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - NB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PB'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PB'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: design/mwsm_scale.sv
// Pipelined restoring divider: mag * limit / largest, one quotient bit per stage.
module mwsm_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           in_valid_i,
  input  mwsm_pkg::div_t in_i,
  output logic           out_valid_o,
  output mwsm_pkg::div_t out_o
);

  localparam int NS = mwsm_pkg::DIV_STEPS;
  localparam int NW = mwsm_pkg::NUM_WHEELS;
  localparam int NB = mwsm_pkg::NUM_BITS;

  mwsm_pkg::div_t stg_in [NS];
  mwsm_pkg::div_t stg_q  [NS];
  logic [NS-1:0]  vld_q;

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int K = NS - 1 - j;
    mwsm_pkg::div_t step_d;
    logic [NB:0]    diff [NW];

    if (j == 0) begin : g_first
      assign stg_in[j] = in_i;
    end else begin : g_next
      assign stg_in[j] = stg_q[j-1];
    end

    always_comb begin
      step_d = stg_in[j];
      for (int w = 0; w < NW; w++) begin
        diff[w] = {1'b0, stg_in[j].w[w].rem} - ((NB + 1)'(stg_in[j].d) << K);
        if (!diff[w][NB]) begin
          step_d.w[w].rem    = diff[w][NB-1:0];
          step_d.w[w].quo[K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stg_q[j] <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  assign out_o       = stg_q[NS-1];
  assign out_valid_o = vld_q[NS-1];

endmodule

FILE: design/mwsm_back.sv
// Wheel mixing pipeline, rpm conversion, desaturation and the result queue.
module mwsm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mwsm_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  mwsm_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mwsm_pkg::res_t res_o
);

  localparam int NW  = mwsm_pkg::NUM_WHEELS;
  localparam int MS  = 7;
  localparam int AB  = mwsm_pkg::ARM_BITS;
  localparam int LB  = mwsm_pkg::LIN_BITS;
  localparam int WB  = mwsm_pkg::WARM_BITS;
  localparam int KB  = mwsm_pkg::WK_BITS;
  localparam int SB  = mwsm_pkg::SUM_BITS;
  localparam int MB  = mwsm_pkg::MAG_BITS;
  localparam int HB  = mwsm_pkg::HALF_BITS;
  localparam int PLB = mwsm_pkg::PROD_LO_BITS;
  localparam int PHB = mwsm_pkg::PROD_HI_BITS;
  localparam int FB  = mwsm_pkg::FULL_BITS;
  localparam int FRB = mwsm_pkg::RPM_FRAC_BITS;
  localparam int RMB = mwsm_pkg::RPM_MAG_BITS;
  localparam int NB  = mwsm_pkg::NUM_BITS;
  localparam int RB  = mwsm_pkg::RPM_BITS;
  localparam int QB  = mwsm_pkg::Q_BITS;
  localparam int RPB = mwsm_pkg::RES_PTR_BITS;
  localparam int RCB = mwsm_pkg::RES_CNT_BITS;

  logic [MS-1:0] vld_q;
  logic          adv;
  logic          out_vld;
  logic          rq_full, rq_push, rq_pop;

  // Stage 1: linear terms and yaw times lever arm.
  logic signed [AB-1:0] arm      [NW];
  logic signed [LB-1:0] vx_e, vy_e;
  logic signed [LB-1:0] lin_d    [NW];
  logic signed [WB-1:0] warm_d   [NW];
  logic signed [LB-1:0] s1_lin_q [NW];
  logic signed [WB-1:0] s1_warm_q[NW];
  // Stage 2: times 1/57.3 in Q16.
  logic signed [LB-1:0] s2_lin_q [NW];
  logic signed [KB-1:0] s2_wk_q  [NW];
  // Stage 3: full Q16 wheel sum.
  logic signed [SB-1:0] s3_sum_q [NW];
  // Stage 4: sign and magnitude.
  logic                 s4_neg_q [NW];
  logic [MB-1:0]        s4_mag_q [NW];
  // Stage 5: split multiply by the rpm gain.
  logic                 s5_neg_q [NW];
  logic [PLB-1:0]       s5_plo_q [NW];
  logic [PHB-1:0]       s5_phi_q [NW];
  // Stage 6: integer rpm magnitude.
  logic [FB-1:0]        full_d   [NW];
  logic                 s6_neg_q [NW];
  logic [RMB-1:0]       s6_rpm_q [NW];
  // Stage 7: largest magnitude and divider numerators.
  logic [RMB-1:0]       max01, max23, largest_d;
  logic                 s7_neg_q [NW];
  logic [RMB-1:0]       s7_rpm_q [NW];
  logic [NB-1:0]        s7_num_q [NW];
  logic [RMB-1:0]       s7_largest_q;

  mwsm_pkg::div_t div_in, div_out;
  logic [RMB-1:0] mag_sel [NW];
  logic [RMB-1:0] lim_mag [NW];
  logic [RMB-1:0] clip    [NW];
  mwsm_pkg::res_t res_d;

  mwsm_pkg::res_t rq_mem_q [mwsm_pkg::RES_DEPTH];
  logic [RPB-1:0] rq_wr_q, rq_rd_q;
  logic [RCB-1:0] rq_cnt_q, rq_cnt_d;

  // The whole pipeline holds only when a finished word cannot enter the queue.
  assign adv       = ~(out_vld & rq_full);
  assign cmd_pop_o = adv & cmd_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[MS-2:0], cmd_valid_i};
    end
  end

  always_comb begin
    vx_e = LB'(cmd_i.vx);
    vy_e = LB'(cmd_i.vy);
    for (int i = 0; i < NW; i++) begin
      arm[i] = signed'(AB'(cfg_i.radius))
             + (mwsm_pkg::AX_NEG[i] ? -AB'(cfg_i.off_x) : AB'(cfg_i.off_x))
             + (mwsm_pkg::AY_NEG[i] ? -AB'(cfg_i.off_y) : AB'(cfg_i.off_y));
      lin_d[i]  = (mwsm_pkg::SX_NEG[i] ? -vx_e : vx_e)
                + (mwsm_pkg::SY_NEG[i] ? -vy_e : vy_e);
      warm_d[i] = WB'(cmd_i.wz) * WB'(arm[i]);
      full_d[i] = (FB'(s5_phi_q[i]) << HB) + FB'(s5_plo_q[i]);
    end
  end

  always_comb begin
    max01     = (s6_rpm_q[0] > s6_rpm_q[1]) ? s6_rpm_q[0] : s6_rpm_q[1];
    max23     = (s6_rpm_q[2] > s6_rpm_q[3]) ? s6_rpm_q[2] : s6_rpm_q[3];
    largest_d = (max01 > max23) ? max01 : max23;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NW; i++) begin
        s1_lin_q[i]  <= lin_d[i];
        s1_warm_q[i] <= warm_d[i];
        s2_lin_q[i]  <= s1_lin_q[i];
        s2_wk_q[i]   <= KB'(s1_warm_q[i]) * KB'(mwsm_pkg::INV_DEG_Q16);
        s3_sum_q[i]  <= (SB'(s2_lin_q[i]) <<< QB) + SB'(s2_wk_q[i]);
        s4_neg_q[i]  <= s3_sum_q[i][SB-1];
        s4_mag_q[i]  <= s3_sum_q[i][SB-1] ? MB'(-s3_sum_q[i]) : MB'(s3_sum_q[i]);
        s5_neg_q[i]  <= s4_neg_q[i];
        s5_plo_q[i]  <= PLB'(s4_mag_q[i][HB-1:0]) * PLB'(cfg_i.gain);
        s5_phi_q[i]  <= PHB'(s4_mag_q[i][MB-1:HB]) * PHB'(cfg_i.gain);
        s6_neg_q[i]  <= s5_neg_q[i];
        s6_rpm_q[i]  <= full_d[i][FB-1:FRB];
        s7_neg_q[i]  <= s6_neg_q[i];
        s7_rpm_q[i]  <= s6_rpm_q[i];
        s7_num_q[i]  <= NB'(s6_rpm_q[i]) * NB'(cfg_i.lim_rpm);
      end
      s7_largest_q <= largest_d;
    end
  end

  always_comb begin
    div_in.scaled = s7_largest_q > RMB'(cfg_i.lim_rpm);
    div_in.d      = s7_largest_q;
    for (int i = 0; i < NW; i++) begin
      div_in.w[i].neg     = s7_neg_q[i];
      div_in.w[i].rpm_mag = s7_rpm_q[i];
      div_in.w[i].rem     = s7_num_q[i];
      div_in.w[i].quo     = '0;
    end
  end

  mwsm_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (vld_q[MS-1]),
    .in_i        (div_in),
    .out_valid_o (out_vld),
    .out_o       (div_out)
  );

  // Pick scaled or plain magnitude, saturate to the output width, restore sign.
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      mag_sel[i] = div_out.scaled ? RMB'(div_out.w[i].quo) : div_out.w[i].rpm_mag;
      lim_mag[i] = div_out.w[i].neg ? RMB'(mwsm_pkg::RPM_MAX + 1) : RMB'(mwsm_pkg::RPM_MAX);
      clip[i]    = (mag_sel[i] > lim_mag[i]) ? lim_mag[i] : mag_sel[i];
      res_d.rpm[i] = div_out.w[i].neg ? -RB'(clip[i]) : RB'(clip[i]);
    end
    res_d.was_scaled = div_out.scaled;
  end

  assign rq_full = (rq_cnt_q == RCB'(mwsm_pkg::RES_DEPTH));
  assign empty_o = (rq_cnt_q == '0);
  assign rq_push = out_vld & ~rq_full;
  assign rq_pop  = pop_i & ~empty_o;
  assign res_o   = rq_mem_q[rq_rd_q];

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    if (rq_push && !rq_pop) begin
      rq_cnt_d = rq_cnt_q + RCB'(1);
    end else if (!rq_push && rq_pop) begin
      rq_cnt_d = rq_cnt_q - RCB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_cnt_q <= rq_cnt_d;
      if (rq_push) begin
        rq_wr_q <= rq_wr_q + RPB'(1);
      end
      if (rq_pop) begin
        rq_rd_q <= rq_rd_q + RPB'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_mem_q[rq_wr_q] <= res_d;
    end
  end

endmodule

FILE: design/mecanum_wheel_speed_mixer.sv
// Top level of the mecanum wheel speed mixer: four-wheel inverse kinematics.
//
//   channel   | handshake            | payload
//   ----------+----------------------+----------------------------------------------
//   command   | push / full          | speed_x_i, speed_y_i, yaw_rate_i
//   result    | pop / empty          | rpm_front_right_o .. rpm_back_right_o,
//             |                      | was_scaled_o
//   config    | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One command word is accepted every clock cycle while the command queue is not
// full. A command then passes the seven mixing stages, the fourteen stages of
// the scaling divider, one quotient bit per stage, and the write into the result
// queue. Reset is asynchronous and active low; it empties both queues and loads
// the register defaults. When the result queue is full and a finished word waits
// at the divider output, the whole back pipeline holds for that cycle, even if
// the queue is popped in it; a held pipeline fills the four-entry command queue.
//
// Data flow: the front end clamps each velocity component to its configured
// limit and writes the command into a small queue. The back end pops it, forms
// the four wheel sums in Q16 (linear terms shifted up, yaw times lever arm times
// 1/57.3), converts to rpm with the Q0.24 gain, truncating toward zero, and
// finds the largest magnitude. If that exceeds the rpm limit, every wheel is
// scaled by limit/largest in the pipelined divider. Each result word finally
// waits in a two-entry queue, so the back end keeps running while the consumer
// has not yet taken the oldest word.
module mecanum_wheel_speed_mixer (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Command channel
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [mwsm_pkg::SPEED_BITS-1:0]  speed_x_i,
  input  logic signed [mwsm_pkg::SPEED_BITS-1:0]  speed_y_i,
  input  logic signed [mwsm_pkg::SPEED_BITS-1:0]  yaw_rate_i,
  // Result channel
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [mwsm_pkg::RPM_BITS-1:0]    rpm_front_right_o,
  output logic signed [mwsm_pkg::RPM_BITS-1:0]    rpm_front_left_o,
  output logic signed [mwsm_pkg::RPM_BITS-1:0]    rpm_back_left_o,
  output logic signed [mwsm_pkg::RPM_BITS-1:0]    rpm_back_right_o,
  output logic                                    was_scaled_o,
  // Configuration port
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [mwsm_pkg::PADDR_BITS-1:0]         paddr,
  input  logic [mwsm_pkg::PDATA_BITS-1:0]         pwdata,
  output logic [mwsm_pkg::PDATA_BITS-1:0]         prdata,
  output logic                                    pready
);

  mwsm_pkg::cfg_t cfg;
  mwsm_pkg::cmd_t cmd;
  mwsm_pkg::res_t res;
  logic           cmd_valid;
  logic           cmd_pop;

  // Register accesses complete in their access cycle.
  assign pready = 1'b1;

  mwsm_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  mwsm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .full_o      (full),
    .speed_x_i   (speed_x_i),
    .speed_y_i   (speed_y_i),
    .yaw_rate_i  (yaw_rate_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mwsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  // Wheel order in the result word: front right, front left, back left, back right.
  assign rpm_front_right_o = signed'(res.rpm[mwsm_pkg::WHEEL_FR]);
  assign rpm_front_left_o  = signed'(res.rpm[mwsm_pkg::WHEEL_FL]);
  assign rpm_back_left_o   = signed'(res.rpm[mwsm_pkg::WHEEL_BL]);
  assign rpm_back_right_o  = signed'(res.rpm[mwsm_pkg::WHEEL_BR]);
  assign was_scaled_o      = res.was_scaled;

endmodule

FILE: design/mwsm_checker.sv
// Port-level checker for the mixer, bound to the top level.
module mwsm_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    push,
  input logic                                    full,
  input logic                                    empty,
  input logic                                    pop,
  input logic signed [mwsm_pkg::RPM_BITS-1:0]    rpm_front_right_o,
  input logic signed [mwsm_pkg::RPM_BITS-1:0]    rpm_front_left_o,
  input logic signed [mwsm_pkg::RPM_BITS-1:0]    rpm_back_left_o,
  input logic signed [mwsm_pkg::RPM_BITS-1:0]    rpm_back_right_o,
  input logic                                    was_scaled_o
);

  localparam int OB = 6;

  logic          in_acc, out_acc;
  logic [OB-1:0] outst_q, outst_d;

  assign in_acc  = push & ~full;
  assign out_acc = pop & ~empty;

  // Words accepted but not yet delivered.
  always_comb begin
    outst_d = outst_q;
    if (in_acc && !out_acc) begin
      outst_d = outst_q + OB'(1);
    end else if (!in_acc && out_acc) begin
      outst_d = outst_q - OB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  // A result is only delivered for a command that went in earlier.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (outst_q != '0))
    else $error("result delivered with no command outstanding");

  // With nothing in flight the result side must be empty.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outst_q == '0) |-> empty)
    else $error("result visible while idle");

  // The command side only backs up while work is in flight.
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (outst_q != '0))
    else $error("full raised while idle");

  // A waiting result stays put until it is popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rpm_front_right_o)
                          && $stable(rpm_front_left_o) && $stable(rpm_back_left_o)
                          && $stable(rpm_back_right_o) && $stable(was_scaled_o)))
    else $error("waiting result changed before pop");

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_mwsm_checker (.*);

FILE: sim/tb_mecanum_wheel_speed_mixer.sv
// Self-checking testbench for the mecanum wheel speed mixer.

// Keeps a copy of the register file, predicts the four wheel rpms of every
// accepted command word and compares them with the words the block returns.
class rpm_scoreboard;
  mwsm_pkg::cfg_t expected_cfg_unused_guard;
  mwsm_pkg::cfg_t cfg;
  mwsm_pkg::res_t expected_rpm_q[$];
  int unsigned    mismatches;
  int unsigned    words_checked;
  int unsigned    words_scaled;

  function new();
    cfg.radius  = mwsm_pkg::RADIUS_RST;
    cfg.off_x   = '0;
    cfg.off_y   = '0;
    cfg.gain    = mwsm_pkg::GAIN_RST;
    cfg.lim_vx  = mwsm_pkg::LIMIT_V_RST;
    cfg.lim_vy  = mwsm_pkg::LIMIT_V_RST;
    cfg.lim_wz  = mwsm_pkg::LIMIT_WZ_RST;
    cfg.lim_rpm = mwsm_pkg::LIMIT_RPM_RST;
    expected_cfg_unused_guard = cfg;
    mismatches    = 0;
    words_checked = 0;
    words_scaled  = 0;
  endfunction

  function void set_reg(mwsm_pkg::reg_idx_e idx, logic [mwsm_pkg::PDATA_BITS-1:0] value);
    case (idx)
      mwsm_pkg::REG_RADIUS:    cfg.radius  = value[mwsm_pkg::CFG_LEN_BITS-1:0];
      mwsm_pkg::REG_OFFSET_X:  cfg.off_x   = value[mwsm_pkg::CFG_LEN_BITS-1:0];
      mwsm_pkg::REG_OFFSET_Y:  cfg.off_y   = value[mwsm_pkg::CFG_LEN_BITS-1:0];
      mwsm_pkg::REG_GAIN:      cfg.gain    = value[mwsm_pkg::GAIN_BITS-1:0];
      mwsm_pkg::REG_LIMIT_VX:  cfg.lim_vx  = value[mwsm_pkg::LIMIT_BITS-1:0];
      mwsm_pkg::REG_LIMIT_VY:  cfg.lim_vy  = value[mwsm_pkg::LIMIT_BITS-1:0];
      mwsm_pkg::REG_LIMIT_WZ:  cfg.lim_wz  = value[mwsm_pkg::LIMIT_BITS-1:0];
      mwsm_pkg::REG_LIMIT_RPM: cfg.lim_rpm = value[mwsm_pkg::LIM_RPM_BITS-1:0];
      default: ;
    endcase
  endfunction

  function longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function string wheel_name(int i);
    case (i)
      mwsm_pkg::WHEEL_FR: return "front_right";
      mwsm_pkg::WHEEL_FL: return "front_left";
      mwsm_pkg::WHEEL_BL: return "back_left";
      default:            return "back_right";
    endcase
  endfunction

  // Clamp, mix in Q16, apply the gain and desaturate against the rpm limit.
  function mwsm_pkg::res_t mix_wheels(logic signed [mwsm_pkg::SPEED_BITS-1:0] x,
                                      logic signed [mwsm_pkg::SPEED_BITS-1:0] y,
                                      logic signed [mwsm_pkg::SPEED_BITS-1:0] w);
    longint          vx, vy, wz, r, ox, oy, arm, lin, sum_q16, v;
    longint unsigned mg, gain, lim_rpm, largest, sc;
    longint          rpm_s [mwsm_pkg::NUM_WHEELS];
    longint unsigned mag [mwsm_pkg::NUM_WHEELS];
    logic            scaled;
    int              i;
    mwsm_pkg::res_t  res;
    vx      = clamp_sym(longint'(x), longint'(cfg.lim_vx));
    vy      = clamp_sym(longint'(y), longint'(cfg.lim_vy));
    wz      = clamp_sym(longint'(w), longint'(cfg.lim_wz));
    r       = longint'(cfg.radius);
    ox      = longint'(cfg.off_x);
    oy      = longint'(cfg.off_y);
    gain    = cfg.gain;
    lim_rpm = cfg.lim_rpm;
    largest = 0;
    for (i = 0; i < mwsm_pkg::NUM_WHEELS; i++) begin
      arm     = r + (mwsm_pkg::AX_NEG[i] ? -ox : ox) + (mwsm_pkg::AY_NEG[i] ? -oy : oy);
      lin     = (mwsm_pkg::SX_NEG[i] ? -vx : vx) + (mwsm_pkg::SY_NEG[i] ? -vy : vy);
      sum_q16 = lin * 65536 + wz * arm * longint'(mwsm_pkg::INV_DEG_Q16);
      // Work on the magnitude so the shift truncates toward zero.
      if (sum_q16 < 0) begin
        mg = -sum_q16;
      end else begin
        mg = sum_q16;
      end
      mg = (mg * gain) >> mwsm_pkg::RPM_FRAC_BITS;
      rpm_s[i] = (sum_q16 < 0) ? -longint'(mg) : longint'(mg);
      mag[i]   = mg;
      if (mg > largest) begin
        largest = mg;
      end
    end
    scaled = (largest > lim_rpm);
    for (i = 0; i < mwsm_pkg::NUM_WHEELS; i++) begin
      v = rpm_s[i];
      if (scaled) begin
        sc = mag[i] * lim_rpm / largest;
        v  = (rpm_s[i] < 0) ? -longint'(sc) : longint'(sc);
      end
      if (v > mwsm_pkg::RPM_MAX) begin
        v = mwsm_pkg::RPM_MAX;
      end
      if (v < -mwsm_pkg::RPM_MAX - 1) begin
        v = -mwsm_pkg::RPM_MAX - 1;
      end
      res.rpm[i] = v[mwsm_pkg::RPM_BITS-1:0];
    end
    res.was_scaled = scaled;
    return res;
  endfunction

  function void note_command(logic signed [mwsm_pkg::SPEED_BITS-1:0] x,
                             logic signed [mwsm_pkg::SPEED_BITS-1:0] y,
                             logic signed [mwsm_pkg::SPEED_BITS-1:0] w);
    expected_rpm_q.push_back(mix_wheels(x, y, w));
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task check_wheels(mwsm_pkg::res_t got);
    mwsm_pkg::res_t want;
    int             i;
    if (expected_rpm_q.size() == 0) begin
      report($sformatf("result word %0d arrived with nothing expected", words_checked));
    end else begin
      want = expected_rpm_q.pop_front();
      for (i = 0; i < mwsm_pkg::NUM_WHEELS; i++) begin
        if (got.rpm[i] !== want.rpm[i]) begin
          report($sformatf("word %0d: %s got %0d expected %0d", words_checked,
                           wheel_name(i), $signed(got.rpm[i]), $signed(want.rpm[i])));
        end
      end
      if (got.was_scaled !== want.was_scaled) begin
        report($sformatf("word %0d: was_scaled got %b expected %b", words_checked,
                         got.was_scaled, want.was_scaled));
      end
      if (want.was_scaled) begin
        words_scaled++;
      end
    end
    words_checked++;
  endtask
endclass

module tb_mecanum_wheel_speed_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 2;
  localparam int RESET_CYCLES  = 7;
  localparam int NUM_SETTINGS  = 10;
  localparam int WORDS_PER_SET = 110;
  localparam int MAX_GAP       = 13;
  // A settle time follows the drain so the block is idle before a register write.
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_SETTING  = 5;
  // The limit is well above the slowest correct run: about 1100 words with two
  // random gaps each, plus the settle times and the hold-off.
  localparam int CYCLE_LIMIT   = 400000;

  localparam int SB = mwsm_pkg::SPEED_BITS;
  localparam int RB = mwsm_pkg::RPM_BITS;
  localparam int PB = mwsm_pkg::PDATA_BITS;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           push = 1'b0;
  logic                           full;
  logic signed [SB-1:0]           speed_x_i = '0;
  logic signed [SB-1:0]           speed_y_i = '0;
  logic signed [SB-1:0]           yaw_rate_i = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic signed [RB-1:0]           rpm_front_right_o;
  logic signed [RB-1:0]           rpm_front_left_o;
  logic signed [RB-1:0]           rpm_back_left_o;
  logic signed [RB-1:0]           rpm_back_right_o;
  logic                           was_scaled_o;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [mwsm_pkg::PADDR_BITS-1:0] paddr = '0;
  logic [PB-1:0]                  pwdata = '0;
  logic [PB-1:0]                  prdata;
  logic                           pready;

  rpm_scoreboard sb = new();

  // Shared between the command driver and the result reader. While no_idle is
  // set neither side inserts gaps; hold_cycles asks the reader for one long
  // hold-off, which it counts out in its own process.
  bit          no_idle = 1'b0;
  int          hold_cycles = 0;
  int unsigned full_stall_cycles = 0;
  int unsigned cycle_count = 0;

  mecanum_wheel_speed_mixer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .speed_x_i         (speed_x_i),
    .speed_y_i         (speed_y_i),
    .yaw_rate_i        (yaw_rate_i),
    .empty             (empty),
    .pop               (pop),
    .rpm_front_right_o (rpm_front_right_o),
    .rpm_front_left_o  (rpm_front_left_o),
    .rpm_back_left_o   (rpm_back_left_o),
    .rpm_back_right_o  (rpm_back_right_o),
    .was_scaled_o      (was_scaled_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d words still expected",
               cycle_count, sb.expected_rpm_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // One register write: a setup cycle, then the access cycle, which completes
  // at the edge where pready is seen high. A quiet cycle follows so that
  // back-to-back writes never raise and lower psel in the same time step.
  task automatic write_reg(mwsm_pkg::reg_idx_e idx, logic [PB-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Chassis geometry and limits for each register setting. Setting zero keeps
  // the reset values; one and two hit the top and the bottom of every register.
  task automatic load_chassis_setting(int idx);
    mwsm_pkg::cfg_t c;
    c.radius  = mwsm_pkg::CFG_LEN_BITS'($urandom_range(0, 4095));
    c.off_x   = mwsm_pkg::CFG_LEN_BITS'($urandom);
    c.off_y   = mwsm_pkg::CFG_LEN_BITS'($urandom);
    c.gain    = mwsm_pkg::GAIN_BITS'($urandom);
    c.lim_vx  = mwsm_pkg::LIMIT_BITS'($urandom_range(0, 32767));
    c.lim_vy  = mwsm_pkg::LIMIT_BITS'($urandom_range(0, 32767));
    c.lim_wz  = mwsm_pkg::LIMIT_BITS'($urandom_range(0, 32767));
    c.lim_rpm = mwsm_pkg::LIM_RPM_BITS'($urandom_range(0, 16383));
    case (idx)
      1: begin
        c.radius  = 12'd4095;
        c.off_x   = 12'sd2047;
        c.off_y   = 12'sd2047;
        c.gain    = 24'hFFFFFF;
        c.lim_vx  = 15'd32767;
        c.lim_vy  = 15'd32767;
        c.lim_wz  = 15'd32767;
        c.lim_rpm = 14'd16383;
      end
      2: begin
        // Zero limits force every component to zero, and a zero gain keeps
        // every wheel at zero, so nothing may be scaled.
        c.radius  = 12'd0;
        c.off_x   = -12'sd2048;
        c.off_y   = -12'sd2048;
        c.gain    = 24'd0;
        c.lim_vx  = 15'd0;
        c.lim_vy  = 15'd0;
        c.lim_wz  = 15'd0;
        c.lim_rpm = 14'd0;
      end
      3: begin
        // A zero rpm limit with live wheels: every nonzero word is scaled to zero.
        c.lim_rpm = 14'd0;
        c.lim_vx  = mwsm_pkg::LIMIT_BITS'($urandom_range(0, 4000));
      end
      4: begin
        c.radius  = 12'd4095;
        c.off_x   = -12'sd2048;
        c.off_y   = 12'sd2047;
        c.gain    = 24'hFFFFFF;
        c.lim_vx  = 15'd32767;
        c.lim_vy  = 15'd32767;
        c.lim_wz  = 15'd32767;
      end
      6: begin
        // Modest gain with a low rpm limit so scaling is frequent but partial.
        c.gain    = mwsm_pkg::GAIN_BITS'($urandom_range(100000, 2000000));
        c.lim_rpm = mwsm_pkg::LIM_RPM_BITS'($urandom_range(1, 300));
      end
      default: ;
    endcase
    write_reg(mwsm_pkg::REG_RADIUS,    {20'd0, c.radius});
    write_reg(mwsm_pkg::REG_OFFSET_X,  {20'd0, c.off_x});
    write_reg(mwsm_pkg::REG_OFFSET_Y,  {20'd0, c.off_y});
    write_reg(mwsm_pkg::REG_GAIN,      {8'd0, c.gain});
    write_reg(mwsm_pkg::REG_LIMIT_VX,  {17'd0, c.lim_vx});
    write_reg(mwsm_pkg::REG_LIMIT_VY,  {17'd0, c.lim_vy});
    write_reg(mwsm_pkg::REG_LIMIT_WZ,  {17'd0, c.lim_wz});
    write_reg(mwsm_pkg::REG_LIMIT_RPM, {18'd0, c.lim_rpm});
  endtask

  // Offers one command word and waits until it is taken. The valid is only
  // lowered when a gap follows, so it never drops and rises in one time step.
  task automatic send_command(logic signed [SB-1:0] x,
                              logic signed [SB-1:0] y,
                              logic signed [SB-1:0] w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    speed_x_i  <= x;
    speed_y_i  <= y;
    yaw_rate_i <= w;
    @(posedge clk_i);
    while (full) begin
      full_stall_cycles++;
      @(posedge clk_i);
    end
    sb.note_command(x, y, w);
  endtask

  // Picks a speed component around its clamp bound: mostly inside or just past
  // it, sometimes at a corner, and sometimes anywhere in the 16-bit range so
  // that every input bit toggles.
  function automatic logic signed [SB-1:0] pick_speed(int lim);
    int span;
    int v;
    span = lim + lim / 4 + 2;
    case ($urandom_range(0, 7))
      0, 1: v = int'($signed(SB'($urandom)));
      2: begin
        case ($urandom_range(0, 8))
          0: v = 0;
          1: v = -32768;
          2: v = 32767;
          3: v = lim;
          4: v = -lim;
          5: v = lim + 1;
          6: v = -lim - 1;
          7: v = 1;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 2 * span)) - span;
    endcase
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return v[SB-1:0];
  endfunction

  // Waits until every expected word has come back, then lets the pipeline
  // settle so the next register write finds the block idle.
  task automatic wait_for_drain();
    while (sb.expected_rpm_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result reader: takes one word per handshake, with a random wait before each
  // unless no_idle is set, and performs the long hold-off when the stimulus asks.
  initial begin
    int             gap;
    int             hold;
    mwsm_pkg::res_t got;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        hold        = hold_cycles;
        hold_cycles = 0;
        pop <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (empty);
      // Outputs read here are the values present just before this edge,
      // which is the word this handshake accepted.
      got.rpm[mwsm_pkg::WHEEL_FR] = rpm_front_right_o;
      got.rpm[mwsm_pkg::WHEEL_FL] = rpm_front_left_o;
      got.rpm[mwsm_pkg::WHEEL_BL] = rpm_back_left_o;
      got.rpm[mwsm_pkg::WHEEL_BR] = rpm_back_right_o;
      got.was_scaled              = was_scaled_o;
      sb.check_wheels(got);
    end
  end

  // Main sequence: reset, the directed words under reset values, then a block
  // of random words for each register setting, draining between settings.
  initial begin
    int s;
    int n;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (s = 0; s < NUM_SETTINGS; s++) begin
      if (s > 0) begin
        load_chassis_setting(s);
      end
      // Some settings run without any idling on either side.
      no_idle = (s == 4) || (s == 7) || (s == HOLD_SETTING);
      if (s == HOLD_SETTING) begin
        // The reader stops for a long stretch while commands keep coming, so
        // the result queue, the pipeline and the command queue all fill up.
        hold_cycles = HOLD_CYCLES;
      end
      if (s == 0) begin
        // Zero command, clamp edges on each axis, full-scale corners and
        // single-bit values on all three components.
        send_command(16'sd0, 16'sd0, 16'sd0);
        send_command(16'sd3000, 16'sd0, 16'sd0);
        send_command(-16'sd3000, 16'sd0, 16'sd0);
        send_command(16'sd3001, -16'sd3001, 16'sd0);
        send_command(16'sd0, 16'sd3000, 16'sd0);
        send_command(16'sd0, 16'sd0, 16'sd300);
        send_command(16'sd0, 16'sd0, -16'sd301);
        send_command(16'sd2999, 16'sd2999, 16'sd299);
        send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_command(16'sh8000, 16'sh8000, 16'sh8000);
        send_command(16'sh7FFF, 16'sh8000, 16'sd0);
        send_command(16'sd1, -16'sd1, 16'sd1);
        send_command(-16'sd1, 16'sd1, -16'sd1);
        send_command(16'sd0, 16'sd0, 16'sh7FFF);
      end
      for (n = 0; n < WORDS_PER_SET; n++) begin
        send_command(pick_speed(int'(sb.cfg.lim_vx)),
                     pick_speed(int'(sb.cfg.lim_vy)),
                     pick_speed(int'(sb.cfg.lim_wz)));
      end
      push <= 1'b0;
      // The sender pauses here until every word of this setting has come back.
      wait_for_drain();
    end

    while (sb.expected_rpm_q.size() != 0) begin
      sb.report($sformatf("expected word never arrived (%0d left)",
                          sb.expected_rpm_q.size()));
      void'(sb.expected_rpm_q.pop_front());
    end

    $display("Run covered %0d result words over %0d register settings, %0d desaturated.",
             sb.words_checked, NUM_SETTINGS, sb.words_scaled);
    $display("Command input was held off by a full queue for %0d cycles; %0d mismatches.",
             full_stall_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
